FILE: src/icfr_pkg.sv
package icfr_pkg;

    // Default frame buffer depth in bytes
    localparam int FRAME_DEPTH_DEF = 64;

    // Reset value of the idle timeout register, in ticks
    localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd60;

    // Received command codes
    localparam logic [7:0] CODE_STX     = 8'h02;
    localparam logic [7:0] CODE_ETX     = 8'h03;
    localparam logic [7:0] CODE_LF      = 8'h0A;
    localparam logic [7:0] CODE_CR      = 8'h0D;
    localparam logic [7:0] CODE_ACK     = 8'h06;
    localparam logic [7:0] CODE_NAK     = 8'h15;
    localparam logic [7:0] CODE_TIMEOUT = 8'h17;
    localparam logic [7:0] CODE_POWER   = 8'h21;
    localparam logic [7:0] CODE_BRIGHT  = 8'h2D;
    localparam logic [7:0] CODE_DIM     = 8'h2B;
    localparam logic [7:0] CODE_MAX     = 8'h3E;
    localparam logic [7:0] CODE_MIN     = 8'h3C;

    // Reply codes sent back
    localparam logic [1:0] REPLY_ACK     = 2'd0;
    localparam logic [1:0] REPLY_NAK     = 2'd1;
    localparam logic [1:0] REPLY_TIMEOUT = 2'd2;

    // Lamp events
    localparam logic [2:0] LAMP_NONE   = 3'd0;
    localparam logic [2:0] LAMP_POWER  = 3'd1;
    localparam logic [2:0] LAMP_BRIGHT = 3'd2;
    localparam logic [2:0] LAMP_DIM    = 3'd3;
    localparam logic [2:0] LAMP_MAX    = 3'd4;
    localparam logic [2:0] LAMP_MIN    = 3'd5;

    // Reports of partner codes
    localparam logic [1:0] REMOTE_NONE    = 2'd0;
    localparam logic [1:0] REMOTE_ACK     = 2'd1;
    localparam logic [1:0] REMOTE_NAK     = 2'd2;
    localparam logic [1:0] REMOTE_TIMEOUT = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SUM,
        S_SUM_END,
        S_VERDICT,
        S_PAY,
        S_EMIT
    } t_state;

    // Control of the XOR check unit
    typedef struct packed {
        logic clear;
        logic acc;
    } t_chk_ctrl;

endpackage

FILE: src/icfr_ram.sv
module icfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = icfr_pkg::FRAME_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/icfr_chk.sv
module icfr_chk (
    input  logic                i_clk,
    input  icfr_pkg::t_chk_ctrl i_ctrl,
    input  logic [7:0]          i_data,
    output logic                o_zero
);

    logic [7:0] r_acc;
    logic [7:0] n_acc;

    // Running XOR over the stored frame bytes
    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.clear) begin
            n_acc = 8'd0;
        end else if (i_ctrl.acc) begin
            n_acc = r_acc ^ i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // XOR of all bytes is zero exactly when the check byte matches the rest
    assign o_zero = (r_acc == 8'd0);

endmodule

FILE: src/ir_command_frame_receiver.sv
// Channel   Direction  Handshake                Payload
// in        input      i_in_valid / o_in_stall  i_packet_valid, i_command_byte
// out       output     o_out_valid / i_out_stall reply, echo, lamp, remote, payload,
//                                               last, in_frame
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (idle_timeout_ticks)
//
// A tick that does not close a frame goes through transfer, decode and result.
// Closing a checked frame of N stored bytes runs a pass through the single XOR unit
// and the buffer read port, then gives one result a cycle while the output is not
// stalled (the reply alone, or N - 1 payload bytes) and returns to idle.
// Synchronous active-low reset clears control state; the buffer needs no clearing.
// The block stalls its input from a transfer until the last result is registered;
// an output stall holds the result register and the sequencer waits on it.
module ir_command_frame_receiver #(
    parameter int FRAME_DEPTH = icfr_pkg::FRAME_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input tick channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_packet_valid,
    input  logic [7:0]  i_command_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_reply_send,
    output logic [1:0]  o_reply_code,
    output logic        o_echo_valid,
    output logic [7:0]  o_echo_byte,
    output logic [2:0]  o_lamp_cmd,
    output logic [1:0]  o_remote_report,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic        o_last,
    output logic        o_in_frame,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int CW = $clog2(FRAME_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(FRAME_DEPTH);

    icfr_pkg::t_state    r_state, n_state;
    icfr_pkg::t_chk_ctrl chk_ctrl;

    logic          r_in_pv;
    logic [7:0]    r_in_byte;
    logic          r_frame, n_frame;
    logic [15:0]   r_idle, n_idle;
    logic [15:0]   r_limit;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [AW-1:0] r_ptr, n_ptr;
    logic          r_acc_en, n_acc_en;

    // pending final-result fields
    logic          r_p_send, n_p_send;
    logic [1:0]    r_p_code, n_p_code;
    logic [2:0]    r_p_lamp, n_p_lamp;
    logic [1:0]    r_p_remote, n_p_remote;
    logic          r_p_echo_v, n_p_echo_v;

    // result register
    logic          r_out_valid;
    logic          r_o_send, n_o_send;
    logic [1:0]    r_o_code, n_o_code;
    logic          r_o_echo_v, n_o_echo_v;
    logic [7:0]    r_o_echo_b, n_o_echo_b;
    logic [2:0]    r_o_lamp, n_o_lamp;
    logic [1:0]    r_o_remote, n_o_remote;
    logic          r_o_pay_v, n_o_pay_v;
    logic [7:0]    r_o_pay_b, n_o_pay_b;
    logic          r_o_last, n_o_last;
    logic          r_o_frame, n_o_frame;

    logic          in_xfer;
    logic          out_free;
    logic          load_out;
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic          chk_zero;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Frame buffer
    icfr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_in_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Shared XOR check unit
    icfr_chk u_chk (
        .i_clk  (i_clk),
        .i_ctrl (chk_ctrl),
        .i_data (ram_rdata),
        .o_zero (chk_zero)
    );

    // Sequencer: next state, buffer access and result loading
    always_comb begin
        logic          fm;
        logic          term;
        logic [15:0]   idle_eff;
        logic          sum_last;
        logic          pay_last;

        n_state    = r_state;
        n_frame    = r_frame;
        n_idle     = r_idle;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_ptr      = r_ptr;
        n_acc_en   = 1'b0;
        n_p_send   = r_p_send;
        n_p_code   = r_p_code;
        n_p_lamp   = r_p_lamp;
        n_p_remote = r_p_remote;
        n_p_echo_v = r_p_echo_v;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = r_ptr;
        chk_ctrl.clear = 1'b0;
        chk_ctrl.acc   = r_acc_en;
        load_out   = 1'b0;
        n_o_send   = r_o_send;
        n_o_code   = r_o_code;
        n_o_echo_v = r_o_echo_v;
        n_o_echo_b = r_o_echo_b;
        n_o_lamp   = r_o_lamp;
        n_o_remote = r_o_remote;
        n_o_pay_v  = r_o_pay_v;
        n_o_pay_b  = r_o_pay_b;
        n_o_last   = r_o_last;
        n_o_frame  = r_o_frame;

        fm       = r_frame;
        term     = (r_in_byte == icfr_pkg::CODE_CR) || (r_in_byte == icfr_pkg::CODE_LF)
                   || (r_in_byte == icfr_pkg::CODE_ETX);
        idle_eff = r_in_pv ? 16'd0 : r_idle;
        sum_last = ((CW'(r_ptr) + CW'(1)) == r_count);
        pay_last = ((CW'(r_ptr) + CW'(2)) == r_count);

        unique case (r_state)
            icfr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = icfr_pkg::S_DECODE;
                end
            end

            icfr_pkg::S_DECODE: begin
                n_p_send   = 1'b0;
                n_p_code   = icfr_pkg::REPLY_ACK;
                n_p_lamp   = icfr_pkg::LAMP_NONE;
                n_p_remote = icfr_pkg::REMOTE_NONE;
                n_p_echo_v = 1'b0;
                n_state    = icfr_pkg::S_EMIT;
                if (r_in_pv) begin
                    if (r_frame) begin
                        n_p_echo_v = (r_in_byte != 8'd0);
                        if (term) begin
                            fm       = 1'b0;
                            n_p_send = 1'b1;
                            if ((r_count == '0) || r_ovf) begin
                                n_p_code = icfr_pkg::REPLY_NAK;
                                n_count  = '0;
                            end else begin
                                // start the XOR pass over the stored bytes
                                chk_ctrl.clear = 1'b1;
                                n_ptr          = '0;
                                n_state        = icfr_pkg::S_SUM;
                            end
                        end else if (r_count < DEPTH_C) begin
                            ram_we  = 1'b1;
                            n_count = r_count + CW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        unique case (r_in_byte)
                            icfr_pkg::CODE_STX: begin
                                fm      = 1'b1;
                                n_count = '0;
                                n_ovf   = 1'b0;
                            end
                            icfr_pkg::CODE_ACK:     n_p_remote = icfr_pkg::REMOTE_ACK;
                            icfr_pkg::CODE_NAK:     n_p_remote = icfr_pkg::REMOTE_NAK;
                            icfr_pkg::CODE_TIMEOUT: n_p_remote = icfr_pkg::REMOTE_TIMEOUT;
                            icfr_pkg::CODE_POWER:   n_p_lamp   = icfr_pkg::LAMP_POWER;
                            icfr_pkg::CODE_BRIGHT:  n_p_lamp   = icfr_pkg::LAMP_BRIGHT;
                            icfr_pkg::CODE_DIM:     n_p_lamp   = icfr_pkg::LAMP_DIM;
                            icfr_pkg::CODE_MAX:     n_p_lamp   = icfr_pkg::LAMP_MAX;
                            icfr_pkg::CODE_MIN:     n_p_lamp   = icfr_pkg::LAMP_MIN;
                            default: ;
                        endcase
                    end
                end
                // idle timeout on an open frame
                n_idle = idle_eff;
                if (fm) begin
                    if (idle_eff >= r_limit) begin
                        fm       = 1'b0;
                        n_p_send = 1'b1;
                        n_p_code = icfr_pkg::REPLY_TIMEOUT;
                    end
                    n_idle = idle_eff + 16'd1;
                end
                n_frame = fm;
            end

            icfr_pkg::S_SUM: begin
                ram_re   = 1'b1;
                n_acc_en = 1'b1;
                if (sum_last) begin
                    n_state = icfr_pkg::S_SUM_END;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end

            icfr_pkg::S_SUM_END: begin
                n_state = icfr_pkg::S_VERDICT;
            end

            icfr_pkg::S_VERDICT: begin
                // a single stored byte is its own check byte
                if (!(chk_zero || (r_count == CW'(1)))) begin
                    n_p_code = icfr_pkg::REPLY_NAK;
                    n_count  = '0;
                    n_state  = icfr_pkg::S_EMIT;
                end else if (r_count == CW'(1)) begin
                    n_p_code = icfr_pkg::REPLY_ACK;
                    n_count  = '0;
                    n_state  = icfr_pkg::S_EMIT;
                end else begin
                    n_p_code  = icfr_pkg::REPLY_ACK;
                    ram_re    = 1'b1;
                    ram_raddr = '0;
                    n_ptr     = '0;
                    n_state   = icfr_pkg::S_PAY;
                end
            end

            icfr_pkg::S_PAY: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    n_o_pay_v  = 1'b1;
                    n_o_pay_b  = ram_rdata;
                    n_o_last   = pay_last;
                    n_o_frame  = r_frame;
                    n_o_send   = pay_last && r_p_send;
                    n_o_code   = pay_last ? r_p_code : icfr_pkg::REPLY_ACK;
                    n_o_echo_v = pay_last && r_p_echo_v;
                    n_o_echo_b = (pay_last && r_p_echo_v) ? r_in_byte : 8'd0;
                    n_o_lamp   = pay_last ? r_p_lamp : icfr_pkg::LAMP_NONE;
                    n_o_remote = pay_last ? r_p_remote : icfr_pkg::REMOTE_NONE;
                    if (pay_last) begin
                        n_count = '0;
                        n_state = icfr_pkg::S_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_ptr + AW'(1);
                        n_ptr     = r_ptr + AW'(1);
                    end
                end
            end

            icfr_pkg::S_EMIT: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    n_o_pay_v  = 1'b0;
                    n_o_pay_b  = 8'd0;
                    n_o_last   = 1'b1;
                    n_o_frame  = r_frame;
                    n_o_send   = r_p_send;
                    n_o_code   = r_p_send ? r_p_code : icfr_pkg::REPLY_ACK;
                    n_o_echo_v = r_p_echo_v;
                    n_o_echo_b = r_p_echo_v ? r_in_byte : 8'd0;
                    n_o_lamp   = r_p_lamp;
                    n_o_remote = r_p_remote;
                    n_state    = icfr_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = icfr_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= icfr_pkg::S_IDLE;
            r_frame     <= 1'b0;
            r_idle      <= 16'd0;
            r_limit     <= icfr_pkg::IDLE_TIMEOUT_RST;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_acc_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_frame  <= n_frame;
            r_idle   <= n_idle;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_acc_en <= n_acc_en;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_pv   <= i_packet_valid;
            r_in_byte <= i_command_byte;
        end
        r_ptr      <= n_ptr;
        r_p_send   <= n_p_send;
        r_p_code   <= n_p_code;
        r_p_lamp   <= n_p_lamp;
        r_p_remote <= n_p_remote;
        r_p_echo_v <= n_p_echo_v;
        r_o_send   <= n_o_send;
        r_o_code   <= n_o_code;
        r_o_echo_v <= n_o_echo_v;
        r_o_echo_b <= n_o_echo_b;
        r_o_lamp   <= n_o_lamp;
        r_o_remote <= n_o_remote;
        r_o_pay_v  <= n_o_pay_v;
        r_o_pay_b  <= n_o_pay_b;
        r_o_last   <= n_o_last;
        r_o_frame  <= n_o_frame;
    end

    assign o_in_stall      = (r_state != icfr_pkg::S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_reply_send    = r_o_send;
    assign o_reply_code    = r_o_code;
    assign o_echo_valid    = r_o_echo_v;
    assign o_echo_byte     = r_o_echo_b;
    assign o_lamp_cmd      = r_o_lamp;
    assign o_remote_report = r_o_remote;
    assign o_payload_valid = r_o_pay_v;
    assign o_payload_byte  = r_o_pay_b;
    assign o_last          = r_o_last;
    assign o_in_frame      = r_o_frame;

    // Checks
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("input taken while a tick is still in work");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("frame count beyond buffer depth");

    a_payload_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_payload_valid) |-> (!o_in_frame && (o_last == o_reply_send)))
        else $error("payload byte out of a closed, acknowledged frame");

    a_echo_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_echo_valid) |-> (o_echo_byte != 8'd0))
        else $error("zero byte echoed");

    a_reply_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_reply_send || o_echo_valid)) |-> o_last)
        else $error("reply or echo on a result that is not the last");

endmodule

FILE: tb/ir_frame_checker.sv
`timescale 1ns / 1ps

// Watches the tick, result and configuration channels of the IR frame receiver.
// Predicts the results of every accepted tick and compares them in order.
module ir_frame_checker
    import icfr_pkg::*;
#(
    parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick channel
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_packet_valid,
    input  logic [7:0]  i_command_byte,
    // result channel
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_reply_send,
    input  logic [1:0]  i_reply_code,
    input  logic        i_echo_valid,
    input  logic [7:0]  i_echo_byte,
    input  logic [2:0]  i_lamp_cmd,
    input  logic [1:0]  i_remote_report,
    input  logic        i_payload_valid,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_last,
    input  logic        i_in_frame,
    // configuration channel
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // to the top
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic       reply_send;
        logic [1:0] reply_code;
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic [2:0] lamp_cmd;
        logic [1:0] remote_report;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       last;
        logic       in_frame;
    } t_tick_result;

    // Shadow of the receiver state
    logic         frame_mode;
    logic [15:0]  idle_ticks;
    logic [15:0]  timeout_limit;
    logic [7:0]   frame_store [FRAME_DEPTH];
    int           frame_count;
    logic         overflowed;
    t_tick_result tick_results [$];

    initial o_fail_count = 0;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (o_fail_count < 50)
            $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic check_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Work out the results of one tick and queue them
    task automatic receive_tick(input logic pkt, input logic [7:0] b);
        logic         reply_on;
        logic         echo_on;
        logic         accepted;
        logic [1:0]   reply_c;
        logic [1:0]   remote_c;
        logic [2:0]   lamp_c;
        logic [7:0]   sum;
        int           pay_len;
        int           n_res;
        int           i;
        t_tick_result r;
        reply_on = 1'b0;
        echo_on  = 1'b0;
        accepted = 1'b0;
        reply_c  = REPLY_ACK;
        remote_c = REMOTE_NONE;
        lamp_c   = LAMP_NONE;
        pay_len  = 0;
        if (pkt) begin
            idle_ticks = '0;
            if (frame_mode) begin
                if (b == CODE_CR || b == CODE_LF || b == CODE_ETX) begin
                    // close and check: XOR of all but the last stored byte
                    frame_mode = 1'b0;
                    reply_on   = 1'b1;
                    if (frame_count == 0 || overflowed) begin
                        reply_c = REPLY_NAK;
                    end else begin
                        sum = frame_store[0];
                        for (i = 1; i + 1 < frame_count; i++)
                            sum ^= frame_store[i];
                        if (sum == frame_store[frame_count - 1]) begin
                            reply_c  = REPLY_ACK;
                            accepted = 1'b1;
                            pay_len  = frame_count - 1;
                        end else begin
                            reply_c = REPLY_NAK;
                        end
                    end
                end else if (frame_count < FRAME_DEPTH) begin
                    frame_store[frame_count] = b;
                    frame_count++;
                end else begin
                    overflowed = 1'b1;
                end
                echo_on = (b != 8'h00);
            end else begin
                case (b)
                    CODE_STX: begin
                        frame_mode  = 1'b1;
                        frame_count = 0;
                        overflowed  = 1'b0;
                    end
                    CODE_ACK:     remote_c = REMOTE_ACK;
                    CODE_NAK:     remote_c = REMOTE_NAK;
                    CODE_TIMEOUT: remote_c = REMOTE_TIMEOUT;
                    CODE_POWER:   lamp_c   = LAMP_POWER;
                    CODE_BRIGHT:  lamp_c   = LAMP_BRIGHT;
                    CODE_DIM:     lamp_c   = LAMP_DIM;
                    CODE_MAX:     lamp_c   = LAMP_MAX;
                    CODE_MIN:     lamp_c   = LAMP_MIN;
                    default: ;
                endcase
            end
        end

        // idle timeout on an open frame
        if (frame_mode) begin
            if (idle_ticks >= timeout_limit) begin
                frame_mode = 1'b0;
                reply_on   = 1'b1;
                reply_c    = REPLY_TIMEOUT;
            end
            idle_ticks = idle_ticks + 16'd1;
        end

        // one result per payload byte; reply, echo and last ride on the final one
        n_res = (pay_len > 1) ? pay_len : 1;
        for (i = 0; i < n_res; i++) begin
            r = '0;
            if (accepted && i < pay_len) begin
                r.payload_valid = 1'b1;
                r.payload_byte  = frame_store[i];
            end
            r.in_frame = frame_mode;
            if (i == n_res - 1) begin
                r.reply_send    = reply_on;
                r.reply_code    = reply_on ? reply_c : REPLY_ACK;
                r.echo_valid    = echo_on;
                r.echo_byte     = echo_on ? b : 8'h00;
                r.lamp_cmd      = lamp_c;
                r.remote_report = remote_c;
                r.last          = 1'b1;
            end
            tick_results.push_back(r);
        end

        if (reply_on && reply_c != REPLY_TIMEOUT)
            frame_count = 0;
    endtask

    task automatic compare_result();
        t_tick_result want;
        if (tick_results.size() == 0) begin
            report_mismatch("result with none awaited", 8'h00, 8'h00);
            return;
        end
        want = tick_results.pop_front();
        check_field("reply_send",    i_reply_send,    want.reply_send);
        check_field("reply_code",    i_reply_code,    want.reply_code);
        check_field("echo_valid",    i_echo_valid,    want.echo_valid);
        check_field("echo_byte",     i_echo_byte,     want.echo_byte);
        check_field("lamp_cmd",      i_lamp_cmd,      want.lamp_cmd);
        check_field("remote_report", i_remote_report, want.remote_report);
        check_field("payload_valid", i_payload_valid, want.payload_valid);
        check_field("payload_byte",  i_payload_byte,  want.payload_byte);
        check_field("last",          i_last,          want.last);
        check_field("in_frame",      i_in_frame,      want.in_frame);
    endtask

    // Sample every transfer at the clock edge: config, then ticks, then results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_mode    = 1'b0;
            idle_ticks    = '0;
            frame_count   = 0;
            overflowed    = 1'b0;
            timeout_limit = IDLE_TIMEOUT_RST;
            tick_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                timeout_limit = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                receive_tick(i_packet_valid, i_command_byte);
            if (i_out_valid && !i_out_stall)
                compare_result();
        end
        o_pending <= tick_results.size();
    end

endmodule

FILE: tb/tb_ir_command_frame_receiver.sv
`timescale 1ns / 1ps

module tb_ir_command_frame_receiver;
    import icfr_pkg::*;

    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int HOLD_CYCLES  = 300;

    localparam logic [7:0] END_CODES [3] = '{CODE_CR, CODE_LF, CODE_ETX};
    localparam logic [7:0] STRAY_CODES [8] = '{CODE_ACK, CODE_NAK, CODE_TIMEOUT,
        CODE_POWER, CODE_BRIGHT, CODE_DIM, CODE_MAX, CODE_MIN};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        packet_valid;
    logic [7:0]  command_byte;
    logic        out_valid;
    logic        out_stall;
    logic        reply_send;
    logic [1:0]  reply_code;
    logic        echo_valid;
    logic [7:0]  echo_byte;
    logic [2:0]  lamp_cmd;
    logic [1:0]  remote_report;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        last;
    logic        in_frame;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    int          fail_count;
    int          pending;
    int          items_sent    = 0;
    int          cycles        = 0;
    logic [15:0] cur_limit     = IDLE_TIMEOUT_RST;
    bit          idle_on       = 1'b1;
    bit          long_hold_req = 1'b0;

    always #6 clk = ~clk;

    ir_command_frame_receiver u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_packet_valid  (packet_valid),
        .i_command_byte  (command_byte),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_reply_send    (reply_send),
        .o_reply_code    (reply_code),
        .o_echo_valid    (echo_valid),
        .o_echo_byte     (echo_byte),
        .o_lamp_cmd      (lamp_cmd),
        .o_remote_report (remote_report),
        .o_payload_valid (payload_valid),
        .o_payload_byte  (payload_byte),
        .o_last          (last),
        .o_in_frame      (in_frame),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    ir_frame_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_packet_valid  (packet_valid),
        .i_command_byte  (command_byte),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_reply_send    (reply_send),
        .i_reply_code    (reply_code),
        .i_echo_valid    (echo_valid),
        .i_echo_byte     (echo_byte),
        .i_lamp_cmd      (lamp_cmd),
        .i_remote_report (remote_report),
        .i_payload_valid (payload_valid),
        .i_payload_byte  (payload_byte),
        .i_last          (last),
        .i_in_frame      (in_frame),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side back-pressure: random bursts, plus one long hold-off on request
    initial begin : result_stall_gen
        int run;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold_req = 1'b0;
                out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                run = $urandom_range(1, 17);
                out_stall <= 1'b1;
                repeat (run) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic is_end_code(input logic [7:0] b);
        return b == CODE_CR || b == CODE_LF || b == CODE_ETX;
    endfunction

    // Any byte that does not close a frame
    function automatic logic [7:0] data_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (is_end_code(b));
        return b;
    endfunction

    // One tick transfer; an optional gap goes in front of it
    task automatic send_tick(input logic pv, input logic [7:0] b, input bit counted);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        packet_valid <= pv;
        command_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        if (counted)
            items_sent++;
    endtask

    task automatic send_empty_ticks(input int n);
        repeat (n) send_tick(1'b0, 8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Wait until every queued result has been transferred
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_timeout(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_limit = v;
    endtask

    // STX, len stored bytes ending in the XOR check byte, then a closing code.
    // corrupt spoils the check byte; abandon drops the close and, for a limit of 24 or less, lets it time out.
    task automatic send_frame(input int len, input bit corrupt, input bit abandon);
        logic [7:0] body [$];
        logic [7:0] sum;
        logic [7:0] b;
        int         i;
        do begin
            body.delete();
            sum = 8'h00;
            for (i = 0; i < len - 1; i++) begin
                b = data_byte();
                body.push_back(b);
                sum ^= b;
            end
            if (len == 1)
                sum = data_byte();
            if (corrupt)
                sum ^= 8'h01 << $urandom_range(0, 7);
        end while (is_end_code(sum));
        if (len > 0)
            body.push_back(sum);

        send_tick(1'b1, CODE_STX, 1'b1);
        foreach (body[j]) begin
            if ($urandom_range(0, 7) == 0)
                send_empty_ticks($urandom_range(1, 3));
            send_tick(1'b1, body[j], 1'b1);
        end
        if (abandon) begin
            if (cur_limit <= 24)
                send_empty_ticks(int'(cur_limit) + 1);
        end else begin
            send_tick(1'b1, END_CODES[$urandom_range(0, 2)], 1'b1);
        end
    endtask

    initial begin : stimulus
        logic [15:0] limits [5];
        int          quotas [5];
        int          ph;
        int          pick;
        int          len;
        int          phase_end;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        packet_valid <= 1'b0;
        command_byte <= 8'h00;
        cfg_valid    <= 1'b0;
        cfg_data     <= 16'h0000;
        limits = '{16'd0, 16'hFFFF, 16'd3, 16'd0, 16'd60};
        limits[3] = 16'($urandom_range(1, 12));
        quotas = '{15, 35, 40, 40, 50};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every partner and lamp code, unknown codes, then frames
        foreach (STRAY_CODES[k])
            send_tick(1'b1, STRAY_CODES[k], 1'b1);
        send_tick(1'b1, 8'hFF, 1'b1);
        send_tick(1'b0, 8'hFF, 1'b1);
        // empty frame
        send_tick(1'b1, CODE_STX, 1'b1);
        send_tick(1'b1, CODE_ETX, 1'b1);
        // single stored zero byte, matches itself
        send_tick(1'b1, CODE_STX, 1'b1);
        send_tick(1'b1, 8'h00, 1'b1);
        send_tick(1'b1, CODE_CR, 1'b1);
        // good frame carrying STX as data
        send_tick(1'b1, CODE_STX, 1'b1);
        send_tick(1'b1, CODE_STX, 1'b1);
        send_tick(1'b1, 8'hFF, 1'b1);
        send_tick(1'b1, 8'hFD, 1'b1);
        send_tick(1'b1, CODE_LF, 1'b1);
        // bad check byte, with a zero byte
        send_tick(1'b1, CODE_STX, 1'b1);
        send_tick(1'b1, 8'h11, 1'b1);
        send_tick(1'b1, 8'h22, 1'b1);
        send_tick(1'b1, 8'h00, 1'b1);
        send_tick(1'b1, CODE_ETX, 1'b1);

        // Random phases, one timeout setting each
        items_sent = 0;
        for (ph = 0; ph < 5; ph++) begin
            wait_drained();
            repeat (8) @(posedge clk);
            write_timeout(limits[ph]);
            if (ph == 1) begin
                // block the results while a frame of full buffer depth keeps coming
                long_hold_req = 1'b1;
                send_frame(FRAME_DEPTH_DEF, 1'b0, 1'b0);
            end
            if (ph == 4)
                send_frame(FRAME_DEPTH_DEF + 2, 1'b0, 1'b0);
            phase_end = items_sent + quotas[ph];
            while (items_sent < phase_end) begin
                if (ph == 4 && phase_end - items_sent < 40)
                    idle_on = 1'b0;
                else if ($urandom_range(0, 19) == 0)
                    idle_on = !idle_on;
                pick = $urandom_range(0, 15);
                if ($urandom_range(0, 29) == 0)
                    len = $urandom_range(FRAME_DEPTH_DEF - 4, FRAME_DEPTH_DEF + 2);
                else
                    len = $urandom_range(1, 8);
                if (pick < 9)
                    send_frame(len, 1'b0, 1'b0);
                else if (pick < 11)
                    send_frame(len, 1'b1, 1'b0);
                else if (pick == 11)
                    send_frame(0, 1'b0, 1'b0);
                else if (pick == 12)
                    send_frame($urandom_range(0, 4), 1'b0, 1'b1);
                else if (pick == 13)
                    send_tick(1'b1, STRAY_CODES[$urandom_range(0, 7)], 1'b1);
                else
                    send_tick(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b1);
            end
        end

        // Drain and let any stray result show up
        wait_drained();
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
